// File: design/frrw_pkg.sv
// Shared types and constants of the fragment reassembly window.
package frrw_pkg;

  localparam int SEQ_W  = 8;
  localparam int LEN_W  = 12;
  localparam int CAP_W  = 18;
  localparam int OFF_W  = 18;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 4;
  localparam int CMD_W  = 2;
  localparam int WL_W   = 7;
  localparam int MSA_W  = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int FLG_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE = 2'd0,
    CMD_REASM = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_STORED    = 4'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 4'd1;
  localparam logic [STAT_W-1:0] ST_TOO_FAR   = 4'd2;
  localparam logic [STAT_W-1:0] ST_DUP       = 4'd3;
  localparam logic [STAT_W-1:0] ST_NO_CHUNK  = 4'd4;
  localparam logic [STAT_W-1:0] ST_DELIVERED = 4'd5;
  localparam logic [STAT_W-1:0] ST_DISCARDED = 4'd6;
  localparam logic [STAT_W-1:0] ST_SEQ_FAULT = 4'd7;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 4'd8;

  localparam logic [1:0] REG_WIN_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_AHEAD   = 2'd2;

  localparam logic [WL_W-1:0]  WIN_LEN_RST = 7'd32;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 12'd255;
  localparam logic [MSA_W-1:0] AHEAD_RST   = 8'd64;

  // flag bits of a stored fragment
  localparam int FL_START = 0;
  localparam int FL_END   = 1;
  localparam int FL_COMP  = 2;

endpackage

// File: design/frrw_if.sv
// Request and result channel interfaces of the fragment reassembly window.
interface frrw_in_if import frrw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SEQ_W-1:0]   seq_id;
  logic [LEN_W-1:0]   frag_len;
  logic               is_start;
  logic               is_end;
  logic               compressed_in;
  logic [CAP_W-1:0]   capacity;

  modport source(output valid, cmd, seq_id, frag_len, is_start, is_end, compressed_in,
                 capacity, input ready);
  modport sink(input valid, cmd, seq_id, frag_len, is_start, is_end, compressed_in,
               capacity, output ready);
endinterface

interface frrw_out_if import frrw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot;
  logic [LEN_W-1:0]   piece_len;
  logic [OFF_W-1:0]   byte_offset;
  logic               compressed_out;
  logic               scan_more;
  logic               last;

  modport source(output valid, status, slot, piece_len, byte_offset, compressed_out,
                 scan_more, last, input ready);
  modport sink(input valid, status, slot, piece_len, byte_offset, compressed_out,
               scan_more, last, output ready);
endinterface

// File: design/fragment_reorder_reassembly_window.sv
// Sliding-window fragment reassembly: slot bookkeeping, store and reassemble sequencer.
//
// One request is taken at a time; in_ch.ready is high only while the sequencer
// idles. A store request passes through the accept step, a bit-serial remainder
// unit that maps the sequence offset onto a slot, a decision step, a memory read,
// the check-and-write step and the hand-over of the result; a window slide by
// less than its length first steps through the slots that drop off the window.
// A reassemble request scans the window from its start, each slot with a memory
// read and then an evaluate step, evaluates the chunk, and then emits each piece
// of the chunk with a memory read and an emit step plus the output handshake.
// Every result sits in an output register until the sink takes it. Slot length,
// sequence and flags live in one synchronous memory with a registered read;
// per-slot occupancy is kept in flip-flops, so clearing the window (clear
// request, sequence fault or a change of window_length or max_frag_len) is
// immediate and needs no clearing pass. Payload bytes are kept outside: a stored
// fragment belongs at slot*max_frag_len. Registers sit at byte addresses 0
// (window_length), 4 (max_frag_len) and 8 (ahead limit); write them only while
// the block is idle.
module fragment_reorder_reassembly_window import frrw_pkg::*; #(
  parameter int WINDOW_SLOTS = 64,
  parameter int SEQ_SPACE    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  frrw_in_if.sink           in_ch,
  frrw_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IW = $clog2(WINDOW_SLOTS);
  localparam int LW = $clog2(WINDOW_SLOTS + 1);
  localparam int NW = SEQ_W + 1;
  localparam int MW = LEN_W + SEQ_W + FLG_W;
  localparam logic [LW-1:0] LMAX   = LW'(WINDOW_SLOTS);
  localparam logic [NW-1:0] SEQ_SP = NW'(SEQ_SPACE);
  localparam logic [3:0]    MOD_STEPS = 4'(NW);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_MOD     = 11'b000_0000_0010,
    S_DECIDE  = 11'b000_0000_0100,
    S_SLIDE   = 11'b000_0000_1000,
    S_ST_RD   = 11'b000_0001_0000,
    S_ST_CHK  = 11'b000_0010_0000,
    S_SCAN_RD = 11'b000_0100_0000,
    S_SCAN_EX = 11'b000_1000_0000,
    S_EVAL    = 11'b001_0000_0000,
    S_EM_RD   = 11'b010_0000_0000,
    S_EM_EX   = 11'b100_0000_0000
  } state_t;

  // config registers
  logic [WL_W-1:0]   wl_r;
  logic [LEN_W-1:0]  mfl_r;
  logic [MSA_W-1:0]  msa_r;

  // window bookkeeping
  logic [WINDOW_SLOTS-1:0] vld_r;
  logic [LW-1:0]     cnt_r;
  logic [IW-1:0]     si_r;
  logic [SEQ_W-1:0]  ss_r;

  // sequencer
  state_t            st_r;
  state_t            ret_r;
  logic              wait_r;

  // captured request
  logic [SEQ_W-1:0]  seq_r;
  logic [LEN_W-1:0]  len_r;
  logic [FLG_W-1:0]  flg_r;
  logic [CAP_W-1:0]  cap_r;
  logic [SEQ_W-1:0]  off_r;

  // remainder unit
  logic [NW-1:0]     num_r;
  logic [LW-1:0]     rem_r;
  logic [3:0]        mcnt_r;

  // slide loop
  logic [LW-1:0]     scnt_r;
  logic [IW-1:0]     sp_r;

  // scan and emit
  logic [IW-1:0]     w_r;
  logic [SEQ_W-1:0]  cur_r;
  logic [LW-1:0]     n_r;
  logic [LW-1:0]     nfr_r;
  logic [CAP_W-1:0]  clen_r;
  logic [IW-1:0]     cst_r;
  logic              comp_r;
  logic              inv_r;
  logic              fend_r;
  logic [LW-1:0]     k_r;
  logic [OFF_W-1:0]  pos_r;

  // result register
  logic              ovld_r;
  logic [STAT_W-1:0] o_stat_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [LEN_W-1:0]  o_len_r;
  logic [OFF_W-1:0]  o_off_r;
  logic              o_comp_r;
  logic              o_more_r;
  logic              o_last_r;

  // slot memory: {length, sequence, flags}
  logic [MW-1:0]     mem [WINDOW_SLOTS];
  logic [MW-1:0]     rd_r;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [MW-1:0]     mem_wd;
  logic [IW-1:0]     mem_ra;

  // combinational helpers
  logic [LW-1:0]     eff_l;
  logic [LEN_W-1:0]  mfl_eff;
  logic [LEN_W-1:0]  stored_len;
  logic [NW-1:0]     off_in;
  logic              in_bad;
  logic [LW:0]       mstep;
  logic [IW-1:0]     dest;
  logic [IW-1:0]     dest_nx;
  logic [NW-1:0]     off_n;
  logic [NW-1:0]     l_n;
  logic [NW-1:0]     s_n;
  logic [NW-1:0]     ss_sum;
  logic [IW-1:0]     sp_nx;
  logic [IW-1:0]     w_nx;
  logic [IW-1:0]     ew_nx;
  logic [SEQ_W-1:0]  cur_nx;
  state_t            scan_nx;
  logic [LEN_W-1:0]  rd_len;
  logic [SEQ_W-1:0]  rd_seq;
  logic [FLG_W-1:0]  rd_flg;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic              acc;

  assign rd_len = rd_r[MW-1 -: LEN_W];
  assign rd_seq = rd_r[FLG_W +: SEQ_W];
  assign rd_flg = rd_r[FLG_W-1:0];

  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_WIN_LEN: prdata = DATA_W'(wl_r);
      REG_MAX_LEN: prdata = DATA_W'(mfl_r);
      REG_AHEAD:   prdata = DATA_W'(msa_r);
      default:     prdata = '0;
    endcase
  end

  // clamp the slot count to 1..WINDOW_SLOTS
  always_comb begin
    if (wl_r == '0) begin
      eff_l = LW'(1);
    end else if (wl_r > WL_W'(WINDOW_SLOTS)) begin
      eff_l = LMAX;
    end else begin
      eff_l = LW'(wl_r);
    end
  end

  assign mfl_eff    = (mfl_r == '0) ? LEN_W'(1) : mfl_r;
  assign stored_len = (len_r < mfl_eff) ? len_r : mfl_eff;

  // offset of the incoming sequence from the window start
  always_comb begin
    off_in = {1'b0, in_ch.seq_id} + SEQ_SP - {1'b0, ss_r};
    if (off_in >= SEQ_SP) begin
      off_in = off_in - SEQ_SP;
    end
  end
  assign in_bad = (in_ch.frag_len == '0) || ({1'b0, in_ch.seq_id} >= SEQ_SP);

  // one restoring remainder step
  always_comb begin
    mstep = {rem_r, num_r[NW-1]};
    if (mstep >= {1'b0, eff_l}) begin
      mstep = mstep - {1'b0, eff_l};
    end
  end

  assign dest    = rem_r[IW-1:0];
  assign dest_nx = (LW'(dest) + LW'(1) == eff_l) ? '0 : dest + IW'(1);
  assign off_n   = {1'b0, off_r};
  assign l_n     = NW'(eff_l);
  assign s_n     = off_n - l_n + NW'(1);

  always_comb begin
    ss_sum = {1'b0, ss_r} + s_n;
    if (ss_sum >= SEQ_SP) begin
      ss_sum = ss_sum - SEQ_SP;
    end
  end

  assign sp_nx   = (LW'(sp_r) + LW'(1) == eff_l) ? '0 : sp_r + IW'(1);
  assign w_nx    = (LW'(w_r) + LW'(1) == eff_l) ? '0 : w_r + IW'(1);
  assign ew_nx   = (LW'(cst_r) + LW'(1) == eff_l) ? '0 : cst_r + IW'(1);
  assign cur_nx  = ({1'b0, cur_r} + NW'(1) == SEQ_SP) ? '0 : cur_r + SEQ_W'(1);
  // advance the scan, or finish it after the last slot of the window
  assign scan_nx = (n_r + LW'(1) == eff_l) ? S_EVAL : S_SCAN_RD;

  // memory port control
  always_comb begin
    mem_we = (st_r == S_ST_CHK) && !(vld_r[dest] && rd_seq == seq_r);
    mem_wa = dest;
    mem_wd = {stored_len, seq_r, flg_r};
    unique case (st_r)
      S_ST_RD:   mem_ra = dest;
      S_SCAN_RD: mem_ra = w_r;
      S_EM_RD:   mem_ra = cst_r;
      default:   mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  assign in_ch.ready = (st_r == S_IDLE) && !wait_r;
  assign acc         = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = ovld_r;
  assign out_ch.status         = o_stat_r;
  assign out_ch.slot           = o_slot_r;
  assign out_ch.piece_len      = o_len_r;
  assign out_ch.byte_offset    = o_off_r;
  assign out_ch.compressed_out = o_comp_r;
  assign out_ch.scan_more      = o_more_r;
  assign out_ch.last           = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= WIN_LEN_RST;
      mfl_r  <= MAX_LEN_RST;
      msa_r  <= AHEAD_RST;
      vld_r  <= '0;
      cnt_r  <= '0;
      si_r   <= '0;
      ss_r   <= '0;
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      wait_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      // config writes; a new geometry empties the window
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WIN_LEN: begin
            if (pwdata[WL_W-1:0] != wl_r) begin
              wl_r  <= pwdata[WL_W-1:0];
              vld_r <= '0;
              cnt_r <= '0;
              si_r  <= '0;
              ss_r  <= '0;
            end
          end
          REG_MAX_LEN: begin
            if (pwdata[LEN_W-1:0] != mfl_r) begin
              mfl_r <= pwdata[LEN_W-1:0];
              vld_r <= '0;
              cnt_r <= '0;
              si_r  <= '0;
              ss_r  <= '0;
            end
          end
          REG_AHEAD:   msa_r <= pwdata[MSA_W-1:0];
          default: ;
        endcase
      end

      // hold a result until the sink takes it, then resume
      if (wait_r) begin
        if (out_ch.ready) begin
          ovld_r <= 1'b0;
          wait_r <= 1'b0;
          st_r   <= ret_r;
        end
      end else begin
        unique case (st_r)
          S_IDLE: begin
            if (acc) begin
              seq_r <= in_ch.seq_id;
              len_r <= in_ch.frag_len;
              flg_r <= {in_ch.compressed_in, in_ch.is_end, in_ch.is_start};
              cap_r <= in_ch.capacity;
              off_r <= off_in[SEQ_W-1:0];
              o_slot_r <= '0;
              o_len_r  <= '0;
              o_off_r  <= '0;
              o_comp_r <= 1'b0;
              o_more_r <= 1'b0;
              o_last_r <= 1'b1;
              ret_r    <= S_IDLE;
              unique case (cmd_t'(in_ch.cmd))
                CMD_STORE: begin
                  if (in_bad) begin
                    o_stat_r <= ST_INVALID;
                    ovld_r   <= 1'b1;
                    wait_r   <= 1'b1;
                  end else begin
                    num_r  <= {1'b0, si_r} + off_in;
                    rem_r  <= '0;
                    mcnt_r <= MOD_STEPS;
                    st_r   <= S_MOD;
                  end
                end
                CMD_REASM: begin
                  if (cnt_r == '0) begin
                    o_stat_r <= ST_NO_CHUNK;
                    ovld_r   <= 1'b1;
                    wait_r   <= 1'b1;
                  end else begin
                    w_r    <= si_r;
                    cur_r  <= ss_r;
                    n_r    <= '0;
                    nfr_r  <= '0;
                    clen_r <= '0;
                    inv_r  <= 1'b0;
                    fend_r <= 1'b0;
                    st_r   <= S_SCAN_RD;
                  end
                end
                CMD_CLEAR: begin
                  vld_r    <= '0;
                  cnt_r    <= '0;
                  si_r     <= '0;
                  ss_r     <= '0;
                  o_stat_r <= ST_CLEARED;
                  ovld_r   <= 1'b1;
                  wait_r   <= 1'b1;
                end
                default: begin
                  o_stat_r <= ST_INVALID;
                  ovld_r   <= 1'b1;
                  wait_r   <= 1'b1;
                end
              endcase
            end
          end

          // one remainder bit per cycle: (start + offset) mod window
          S_MOD: begin
            rem_r  <= mstep[LW-1:0];
            num_r  <= num_r << 1;
            mcnt_r <= mcnt_r - 4'd1;
            if (mcnt_r == 4'd1) begin
              st_r <= S_DECIDE;
            end
          end

          S_DECIDE: begin
            if (off_n >= l_n) begin
              if (off_r > msa_r && cnt_r > LW'(1)) begin
                o_stat_r <= ST_TOO_FAR;
                ovld_r   <= 1'b1;
                wait_r   <= 1'b1;
                st_r     <= S_IDLE;
              end else begin
                // new start is the slot after the target
                si_r <= dest_nx;
                ss_r <= ss_sum[SEQ_W-1:0];
                if (s_n >= l_n) begin
                  vld_r <= '0;
                  cnt_r <= '0;
                  st_r  <= S_ST_RD;
                end else begin
                  scnt_r <= s_n[LW-1:0];
                  sp_r   <= si_r;
                  st_r   <= S_SLIDE;
                end
              end
            end else begin
              st_r <= S_ST_RD;
            end
          end

          // free the slots that drop off the window, one a cycle
          S_SLIDE: begin
            if (vld_r[sp_r]) begin
              vld_r[sp_r] <= 1'b0;
              cnt_r       <= cnt_r - LW'(1);
            end
            sp_r   <= sp_nx;
            scnt_r <= scnt_r - LW'(1);
            if (scnt_r == LW'(1)) begin
              st_r <= S_ST_RD;
            end
          end

          S_ST_RD: st_r <= S_ST_CHK;

          S_ST_CHK: begin
            o_slot_r <= SLOT_W'(dest);
            ovld_r   <= 1'b1;
            wait_r   <= 1'b1;
            st_r     <= S_IDLE;
            if (vld_r[dest] && rd_seq == seq_r) begin
              o_stat_r <= ST_DUP;
              o_len_r  <= rd_len;
            end else begin
              o_stat_r    <= ST_STORED;
              o_len_r     <= stored_len;
              vld_r[dest] <= 1'b1;
              if (!vld_r[dest]) begin
                cnt_r <= cnt_r + LW'(1);
              end
            end
          end

          S_SCAN_RD: st_r <= S_SCAN_EX;

          S_SCAN_EX: begin
            w_r   <= w_nx;
            cur_r <= cur_nx;
            n_r   <= n_r + LW'(1);
            if (!vld_r[w_r]) begin
              nfr_r  <= '0;
              clen_r <= '0;
              st_r   <= scan_nx;
            end else if (rd_seq != cur_r) begin
              // sequence fault empties the window
              o_stat_r <= ST_SEQ_FAULT;
              o_slot_r <= SLOT_W'(w_r);
              ovld_r   <= 1'b1;
              wait_r   <= 1'b1;
              vld_r    <= '0;
              cnt_r    <= '0;
              si_r     <= '0;
              ss_r     <= '0;
              st_r     <= S_IDLE;
            end else if (rd_flg[FL_START]) begin
              if (nfr_r != '0) begin
                inv_r <= 1'b1;
                st_r  <= S_EVAL;
              end else begin
                clen_r <= CAP_W'(rd_len);
                nfr_r  <= LW'(1);
                cst_r  <= w_r;
                comp_r <= rd_flg[FL_COMP];
                fend_r <= rd_flg[FL_END];
                st_r   <= rd_flg[FL_END] ? S_EVAL : scan_nx;
              end
            end else if (nfr_r != '0) begin
              if (rd_flg[FL_COMP] != comp_r) begin
                inv_r <= 1'b1;
                st_r  <= S_EVAL;
              end else begin
                clen_r <= clen_r + CAP_W'(rd_len);
                nfr_r  <= nfr_r + LW'(1);
                fend_r <= rd_flg[FL_END];
                st_r   <= rd_flg[FL_END] ? S_EVAL : scan_nx;
              end
            end else begin
              st_r <= scan_nx;
            end
          end

          S_EVAL: begin
            if (nfr_r == '0 || (!fend_r && !inv_r)) begin
              o_stat_r <= ST_NO_CHUNK;
              ovld_r   <= 1'b1;
              wait_r   <= 1'b1;
              st_r     <= S_IDLE;
            end else begin
              if (clen_r > cap_r) begin
                inv_r <= 1'b1;
              end
              k_r   <= '0;
              pos_r <= '0;
              st_r  <= S_EM_RD;
            end
          end

          S_EM_RD: st_r <= S_EM_EX;

          // emit one piece and free its slot
          S_EM_EX: begin
            o_stat_r <= inv_r ? ST_DISCARDED : ST_DELIVERED;
            o_slot_r <= SLOT_W'(cst_r);
            o_len_r  <= rd_len;
            o_off_r  <= inv_r ? '0 : pos_r;
            o_comp_r <= comp_r;
            o_more_r <= 1'b1;
            o_last_r <= (k_r + LW'(1) == nfr_r);
            ovld_r   <= 1'b1;
            wait_r   <= 1'b1;
            ret_r    <= (k_r + LW'(1) == nfr_r) ? S_IDLE : S_EM_RD;
            st_r     <= S_IDLE;
            if (vld_r[cst_r]) begin
              vld_r[cst_r] <= 1'b0;
              cnt_r        <= cnt_r - LW'(1);
            end
            pos_r <= pos_r + OFF_W'(rd_len);
            k_r   <= k_r + LW'(1);
            cst_r <= ew_nx;
          end

          default: st_r <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == LW'($countones(vld_r)))
    else $error("item count differs from occupied slots");

  a_start_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(si_r) < eff_l)
    else $error("window start beyond window length");

  a_start_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ss_r} < SEQ_SP)
    else $error("window start sequence out of range");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !ovld_r)
    else $error("request taken while a result is pending");
`endif

endmodule
